@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, suspended while reset is active
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked property, active during reset as well
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)

`endif

`endif

@@ design/dpht_pkg.sv @@
`default_nettype none

package dpht_pkg;

    // Table geometry
    localparam int INDEX_BITS = 10;
    localparam int NSLOTS     = 1 << INDEX_BITS;
    localparam int TAG_W      = 64 - INDEX_BITS;

    // Occupancy counter saturates at its all-ones value
    localparam int OCC_W = 11;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic
    {
        FUNC_LOOKUP = 1'b0,
        FUNC_SAVE   = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Input beat
    typedef struct packed
    {
        func_t              func;
        logic [63:0]        key;
        logic signed [31:0] score_in;
        logic [4:0]         depth_in;
        logic [1:0]         node_type_in;
        logic [2:0]         piece_in;
        logic [2:0]         promote_in;
        logic [5:0]         from_in;
        logic [5:0]         to_in;
    } in_t;

    // Output beat
    typedef struct packed
    {
        logic               hit;
        logic               written;
        logic signed [31:0] score_out;
        logic [4:0]         depth_out;
        logic [1:0]         node_type_out;
        logic [2:0]         piece_out;
        logic [2:0]         promote_out;
        logic [5:0]         from_out;
        logic [5:0]         to_out;
        logic [OCC_W-1:0]   occupancy;
    } out_t;

    // Packed slot info: node type, depth, move
    typedef struct packed
    {
        logic [1:0] node_type;
        logic [4:0] depth;
        logic [2:0] piece;
        logic [2:0] promote;
        logic [5:0] from_sq;
        logic [5:0] to_sq;
    } info_t;

    // One table entry
    typedef struct packed
    {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        info_t              info;
        logic signed [31:0] score;
    } slot_t;

    // Classified request as queued for the back end
    typedef struct packed
    {
        func_t                 func;
        logic [INDEX_BITS-1:0] idx;
        logic [TAG_W-1:0]      tag;
        logic signed [31:0]    score;
        info_t                 info;
    } item_t;

endpackage

`default_nettype wire

@@ design/dpht_front.sv @@
`default_nettype none

module dpht_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire dpht_pkg::in_t in_data,
    input  wire logic          clearing,
    output logic               q_valid,
    output dpht_pkg::item_t    q_item,
    input  wire logic          q_pop
);

    dpht_pkg::item_t                  fifo_reg [dpht_pkg::QDEPTH];
    logic [dpht_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [dpht_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [dpht_pkg::QCNT_W-1:0]      count_reg, count_next;
    dpht_pkg::item_t                  item;
    logic                             push;

    // Split the key into slot index and tag, pack the info word
    always_comb
    begin
        item              = '0;
        item.func         = in_data.func;
        item.idx          = in_data.key[dpht_pkg::INDEX_BITS-1:0];
        item.tag          = in_data.key[63:dpht_pkg::INDEX_BITS];
        item.score        = in_data.score_in;
        item.info.node_type = in_data.node_type_in;
        item.info.depth   = in_data.depth_in;
        item.info.piece   = in_data.piece_in;
        item.info.promote = in_data.promote_in;
        item.info.from_sq = in_data.from_in;
        item.info.to_sq   = in_data.to_in;
    end

    // No beats taken while the table is being cleared
    assign in_stall = clearing || (count_reg == dpht_pkg::QCNT_W'(dpht_pkg::QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dpht_pkg::QPTR_W'(dpht_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dpht_pkg::QPTR_W'(dpht_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

@@ design/dpht_back.sv @@
`default_nettype none

module dpht_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_wdata,
    input  wire logic            q_valid,
    input  wire dpht_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output dpht_pkg::out_t       out_data
);

    dpht_pkg::slot_t                   mem [dpht_pkg::NSLOTS];

    dpht_pkg::state_t                  state_reg, state_next;
    logic [dpht_pkg::INDEX_BITS-1:0]   clr_addr_reg, clr_addr_next;
    logic [dpht_pkg::OCC_W-1:0]        fill_reg, fill_next;
    logic                              replace_mode_reg;
    logic                              out_valid_reg, out_valid_next;
    dpht_pkg::out_t                    out_data_reg;
    dpht_pkg::item_t                   item_reg;
    dpht_pkg::slot_t                   rd_data_reg;

    logic                              mem_we;
    logic [dpht_pkg::INDEX_BITS-1:0]   mem_waddr;
    dpht_pkg::slot_t                   mem_wdata;
    logic                              mem_re;
    logic                              out_free;
    logic                              out_load;
    logic                              hit;
    logic                              store;
    dpht_pkg::slot_t                   new_slot;
    dpht_pkg::out_t                    result;

    assign out_free = !out_valid_reg || !out_stall;

    // Slot evaluation on the registered read data
    always_comb
    begin
        hit   = rd_data_reg.valid && (rd_data_reg.tag == item_reg.tag);
        store = !rd_data_reg.valid || !replace_mode_reg
             || (item_reg.info.depth >= rd_data_reg.info.depth);

        new_slot       = '0;
        new_slot.valid = 1'b1;
        new_slot.tag   = item_reg.tag;
        new_slot.info  = item_reg.info;
        new_slot.score = item_reg.score;

        fill_next = fill_reg;
        if (state_reg == dpht_pkg::ST_LOOKUP && out_free
            && item_reg.func == dpht_pkg::FUNC_SAVE && !rd_data_reg.valid
            && fill_reg != '1)
        begin
            fill_next = fill_reg + 1'b1;
        end

        result           = '0;
        result.occupancy = fill_next;
        if (item_reg.func == dpht_pkg::FUNC_LOOKUP)
        begin
            if (hit)
            begin
                result.hit           = 1'b1;
                result.score_out     = rd_data_reg.score;
                result.depth_out     = rd_data_reg.info.depth;
                result.node_type_out = rd_data_reg.info.node_type;
                result.piece_out     = rd_data_reg.info.piece;
                result.promote_out   = rd_data_reg.info.promote;
                result.from_out      = rd_data_reg.info.from_sq;
                result.to_out        = rd_data_reg.info.to_sq;
            end
        end
        else
        begin
            result.written = store;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dpht_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = dpht_pkg::ST_IDLE;
                end
            end
            dpht_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = dpht_pkg::ST_LOOKUP;
                end
            end
            dpht_pkg::ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = dpht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dpht_pkg::ST_CLEAR;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = item_reg.idx;
        mem_wdata     = new_slot;
        mem_re        = 1'b0;
        q_pop         = 1'b0;
        out_load      = 1'b0;
        clearing      = 1'b0;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            dpht_pkg::ST_CLEAR:
            begin
                clearing      = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            dpht_pkg::ST_IDLE:
            begin
                q_pop  = q_valid;
                mem_re = q_valid;
            end
            dpht_pkg::ST_LOOKUP:
            begin
                out_load = out_free;
                mem_we   = out_free && (item_reg.func == dpht_pkg::FUNC_SAVE) && store;
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dpht_pkg::ST_CLEAR;
            clr_addr_reg     <= '0;
            fill_reg         <= '0;
            replace_mode_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                replace_mode_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[q_item.idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ design/depth_preferred_hash_table.sv @@
// Direct-mapped table of search results, one slot per low-key index.
// Input channel (in_valid / in_stall / in_data): a beat is taken when
// in_valid is high and in_stall low. func selects lookup or save.
// Output channel (out_valid / out_stall / out_data): exactly one result
// beat per input beat, in order; it holds while out_stall is high.
// Config: cfg_we / cfg_wdata write replace_mode (reset 1); the user
// must write it only while idle; the block itself does not enforce this.
// An input beat is queued, its slot is read into registers, and the
// result is registered. The engine handles one beat at a time: the slot
// memory's registered read, then the compare-and-write.
// A 2-entry queue sits between the input side and the table engine, so
// input beats keep being taken while a finished result waits.
// Reset: after rst_n releases, a clearing pass walks all 1024 slots, one
// per cycle; in_stall stays high throughout the pass. A stalled output
// holds the engine, the queue then fills and in_stall rises.
`default_nettype none
`include "assert_macros.svh"

module depth_preferred_hash_table
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire dpht_pkg::in_t in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output dpht_pkg::out_t     out_data
);

    logic            q_valid;
    dpht_pkg::item_t q_item;
    logic            q_pop;
    logic            clearing;

    dpht_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    dpht_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // No input beat while slots are being cleared
    `ASSERT_CLK_RST(a_no_accept_clear, clk, rst_n, clearing |-> in_stall)
    // A hit needs at least one filled slot
    `ASSERT_CLK_RST(a_hit_occupied, clk, rst_n, (out_valid && out_data.hit) |-> (out_data.occupancy != '0))
    // Lookup hit and save report are exclusive
    `ASSERT_CLK_RST(a_hit_xor_written, clk, rst_n, out_valid |-> !(out_data.hit && out_data.written))
    // Nothing leaves while reset is held
    `ASSERT_CLK(a_reset_quiet, clk, !rst_n |-> !out_valid)

endmodule

`default_nettype wire

@@ tb/sv/depth_preferred_hash_table_tb.sv @@
`default_nettype none

module depth_preferred_hash_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Replace policy codes
    localparam logic MODE_ALWAYS = 1'b0;
    localparam logic MODE_DEPTH  = 1'b1;

    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 4;
    localparam int END_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int POOL_SIZE      = 64;
    localparam int PHASE_BEATS    = 345;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_we    = 1'b0;
    logic           cfg_wdata = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    dpht_pkg::in_t  in_data   = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    dpht_pkg::out_t out_data;

    // Shadow copy of the slot store, occupancy and policy
    logic                       slot_used  [dpht_pkg::NSLOTS];
    logic [dpht_pkg::TAG_W-1:0] slot_tag   [dpht_pkg::NSLOTS];
    dpht_pkg::out_t             slot_entry [dpht_pkg::NSLOTS];
    logic [dpht_pkg::OCC_W-1:0] fill_count;
    logic                       replace_mode;

    dpht_pkg::out_t pending_results[$];
    logic [63:0]    key_pool[POOL_SIZE];
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             error_count   = 0;
    int             quiet_cycles  = 0;

    depth_preferred_hash_table DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result-side backpressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Table access as the block should perform it; updates the shadow state
    function automatic dpht_pkg::out_t table_access(dpht_pkg::in_t beat);
        logic [dpht_pkg::INDEX_BITS-1:0] idx;
        logic [dpht_pkg::TAG_W-1:0]      tag;
        logic                            store;
        dpht_pkg::out_t                  res;
        res   = '0;
        store = 1'b0;
        idx   = beat.key[dpht_pkg::INDEX_BITS-1:0];
        tag   = beat.key[63:dpht_pkg::INDEX_BITS];
        if (beat.func == dpht_pkg::FUNC_LOOKUP)
        begin
            if (slot_used[idx] && slot_tag[idx] == tag)
            begin
                res     = slot_entry[idx];
                res.hit = 1'b1;
            end
        end
        else
        begin
            // empty slot always taken; occupied slot per policy
            if (!slot_used[idx])
            begin
                store = 1'b1;
                if (fill_count != {dpht_pkg::OCC_W{1'b1}})
                    fill_count = fill_count + 1'b1;
            end
            else if (replace_mode == MODE_ALWAYS)
                store = 1'b1;
            else
                store = (beat.depth_in >= slot_entry[idx].depth_out);
            if (store)
            begin
                slot_used[idx]                = 1'b1;
                slot_tag[idx]                 = tag;
                slot_entry[idx]               = '0;
                slot_entry[idx].score_out     = beat.score_in;
                slot_entry[idx].depth_out     = beat.depth_in;
                slot_entry[idx].node_type_out = beat.node_type_in;
                slot_entry[idx].piece_out     = beat.piece_in;
                slot_entry[idx].promote_out   = beat.promote_in;
                slot_entry[idx].from_out      = beat.from_in;
                slot_entry[idx].to_out        = beat.to_in;
                res.written                   = 1'b1;
            end
        end
        res.occupancy = fill_count;
        return res;
    endfunction

    function automatic dpht_pkg::in_t make_beat(dpht_pkg::func_t f, logic [63:0] k,
                                                logic [31:0] sc, logic [4:0] d,
                                                logic [1:0] nt, logic [2:0] pc,
                                                logic [2:0] pr, logic [5:0] fr,
                                                logic [5:0] to_sq);
        dpht_pkg::in_t beat;
        beat.func         = f;
        beat.key          = k;
        beat.score_in     = sc;
        beat.depth_in     = d;
        beat.node_type_in = nt;
        beat.piece_in     = pc;
        beat.promote_in   = pr;
        beat.from_in      = fr;
        beat.to_in        = to_sq;
        return beat;
    endfunction

    function automatic dpht_pkg::in_t random_beat(dpht_pkg::func_t f, logic [63:0] k);
        return make_beat(f, k, $urandom, 5'($urandom_range(31)), 2'($urandom_range(3)),
                         3'($urandom_range(7)), 3'($urandom_range(7)),
                         6'($urandom_range(63)), 6'($urandom_range(63)));
    endfunction

    // Drive one input beat, hold it until taken, then record its result
    task automatic send_beat(input dpht_pkg::in_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(table_access(beat));
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_replace_mode(input logic mode);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we       <= 1'b0;
        replace_mode  = mode;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        dpht_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result beat with nothing expected, actual %0h",
                         $time, out_data);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(out_data.hit));
                check_field("written", 32'(want.written), 32'(out_data.written));
                check_field("score_out", want.score_out, out_data.score_out);
                check_field("depth_out", 32'(want.depth_out), 32'(out_data.depth_out));
                check_field("node_type_out", 32'(want.node_type_out),
                            32'(out_data.node_type_out));
                check_field("piece_out", 32'(want.piece_out), 32'(out_data.piece_out));
                check_field("promote_out", 32'(want.promote_out),
                            32'(out_data.promote_out));
                check_field("from_out", 32'(want.from_out), 32'(out_data.from_out));
                check_field("to_out", 32'(want.to_out), 32'(out_data.to_out));
                check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
            end
        end
    end

    // Watchdog: too long without any beat moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no progress for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Misses on an empty table, hits at the field extremes, tag mismatch
    task automatic test_lookup_extremes();
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, 64'h0, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_beat(dpht_pkg::FUNC_SAVE, 64'h0, 32'h8000_0000, 5'd0, 2'd0, 3'd0,
                            3'd0, 6'd0, 6'd0));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, 64'h0, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_beat(dpht_pkg::FUNC_SAVE, '1, 32'h7FFF_FFFF, 5'd31, 2'd3, 3'd7,
                            3'd7, 6'd63, 6'd63));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, '1, '0, '0, '0, '0, '0, '0, '0));
        // same index, different tag
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, 64'h3FF, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, 64'h400, '0, '0, '0, '0, '0, '0, '0));
    endtask

    // Depth-preferred policy: shallower save rejected, equal or deeper taken
    task automatic test_depth_replace();
        send_beat(make_beat(dpht_pkg::FUNC_SAVE, '1, 32'h1234_5678, 5'd30, 2'd1, 3'd2,
                            3'd3, 6'd4, 6'd5));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, '1, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_beat(dpht_pkg::FUNC_SAVE, 64'h3FF, 32'hFFFF_FFFF, 5'd31, 2'd2,
                            3'd5, 3'd1, 6'd33, 6'd12));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, '1, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, 64'h3FF, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_beat(dpht_pkg::FUNC_SAVE, 64'h400, 32'h0000_0001, 5'd1, 2'd1,
                            3'd1, 3'd6, 6'd9, 6'd50));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, 64'h0, '0, '0, '0, '0, '0, '0, '0));
    endtask

    // Always-overwrite policy: shallower saves land too
    task automatic test_always_replace();
        write_replace_mode(MODE_ALWAYS);
        send_beat(make_beat(dpht_pkg::FUNC_SAVE, 64'h3FF, 32'h0, 5'd0, 2'd0, 3'd3, 3'd4,
                            6'd17, 6'd40));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, 64'h3FF, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_beat(dpht_pkg::FUNC_SAVE, '1, 32'hDEAD_BEEF, 5'd2, 2'd3, 3'd6,
                            3'd2, 6'd63, 6'd0));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, '1, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_beat(dpht_pkg::FUNC_LOOKUP, 64'h400, '0, '0, '0, '0, '0, '0, '0));
    endtask

    // Mostly save-then-probe sequences on a pool of colliding keys, plus noise
    task automatic test_random_traffic(input logic mode, input int idle_pct,
                                       input int stall_val, input int beats);
        int          sent;
        int          pick;
        logic [63:0] k;
        sent = 0;
        write_replace_mode(mode);
        send_idle_pct = idle_pct;
        stall_pct     = stall_val;
        while (sent < beats)
        begin
            pick = $urandom_range(99);
            k    = key_pool[$urandom_range(POOL_SIZE - 1)];
            if (pick < 55)
            begin
                send_beat(random_beat(dpht_pkg::FUNC_SAVE, k));
                repeat ($urandom_range(2, 1))
                begin
                    send_beat(random_beat(dpht_pkg::FUNC_LOOKUP, k));
                    sent++;
                end
                sent++;
            end
            else if (pick < 85)
            begin
                send_beat(random_beat(dpht_pkg::func_t'($urandom_range(1)), k));
                sent++;
            end
            else
            begin
                send_beat(random_beat(dpht_pkg::func_t'($urandom_range(1)),
                                      {$urandom, $urandom}));
                sent++;
            end
            // occasional full drain mid-phase
            if ($urandom_range(149) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        for (int i = 0; i < dpht_pkg::NSLOTS; i++)
            slot_used[i] = 1'b0;
        fill_count   = '0;
        replace_mode = MODE_DEPTH;

        // key pool: about a third share an index with an earlier key
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            if (i > 0 && $urandom_range(2) == 0)
                key_pool[i][dpht_pkg::INDEX_BITS-1:0] =
                    key_pool[$urandom_range(i - 1)][dpht_pkg::INDEX_BITS-1:0];
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_lookup_extremes();
        test_depth_replace();
        test_always_replace();
        test_random_traffic(MODE_DEPTH, 10, 78, PHASE_BEATS);
        test_random_traffic(MODE_ALWAYS, 78, 10, PHASE_BEATS);
        test_random_traffic(MODE_DEPTH, 0, 0, PHASE_BEATS);

        wait_for_results();
        stall_pct = 0;
        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/dpht_pkg.sv
design/dpht_front.sv
design/dpht_back.sv
design/depth_preferred_hash_table.sv
tb/sv/depth_preferred_hash_table_tb.sv
